### src/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### src/dnts_pkg.sv
package dnts_pkg;

    localparam int MAP_WIDTH          = 144;
    localparam int MAP_HEIGHT         = 72;
    // Must be a power of two.
    localparam int SINE_TABLE_ENTRIES = 1024;

    localparam int ANGLE_W    = 16;
    localparam int COLUMN_W   = 8;
    localparam int ROW_W      = 7;
    localparam int COLOUR_W   = 8;
    localparam int TRIG_W     = 17;
    localparam int PROD_W     = 2 * TRIG_W;
    localparam int SUM_W      = PROD_W + TRIG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SUN_LONGITUDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_DECLINATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE       = 2'd2;

    localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
    localparam int QTR_N      = SINE_TABLE_ENTRIES / 4;
    localparam int QTR_W      = SINE_IDX_W - 2;
    localparam int PHASE_STEP = 65536 / SINE_TABLE_ENTRIES;
    localparam int LAT_DIV    = 2 * MAP_HEIGHT;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic [ANGLE_W-1:0]        t_mag;
    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef t_mag   t_qtr_table [QTR_N];
    typedef t_angle t_lon_table [2**COLUMN_W];
    typedef t_angle t_lat_table [2**ROW_W];

    typedef struct packed {
        logic [COLOUR_W-1:0] day_colour;
        logic [COLOUR_W-1:0] night_colour;
        logic                world_bit;
    } t_pixel;

    // Polynomial approximation of a quarter sine wave, evaluated at elaboration.
    function automatic longint quarter_sine(input longint x);
        longint t;
        longint u;
        longint v;
        longint w;
        t = (x * x) >>> 14;
        u = 42048 - ((4640 * t) >>> 14);
        v = 102944 - ((u * t) >>> 14);
        w = (v * x) >>> 14;
        return (w * 65535 + 32768) >>> 16;
    endfunction

    function automatic t_qtr_table build_qtr_table();
        t_qtr_table tab;
        for (int i = 0; i < QTR_N; i++) begin
            tab[i] = t_mag'(quarter_sine(longint'(i) * PHASE_STEP));
        end
        return tab;
    endfunction

    function automatic t_lon_table build_lon_table();
        t_lon_table tab;
        for (int i = 0; i < 2**COLUMN_W; i++) begin
            tab[i] = t_angle'((longint'(i) * 65536) / MAP_WIDTH);
        end
        return tab;
    endfunction

    function automatic t_lat_table build_lat_table();
        t_lat_table tab;
        for (int i = 0; i < 2**ROW_W; i++) begin
            tab[i] = t_angle'((longint'(i) * 65536) / LAT_DIV + 49152);
        end
        return tab;
    endfunction

    localparam t_qtr_table QTR_TABLE = build_qtr_table();
    localparam t_lon_table LON_TABLE = build_lon_table();
    localparam t_lat_table LAT_TABLE = build_lat_table();
    localparam t_mag       MAG_PEAK  = t_mag'(quarter_sine(longint'(16384)));

    // Sine of an angle in 1/65536 turns, scaled to +-65535, from the quarter table.
    function automatic t_trig sine_lookup(input t_angle angle);
        logic [SINE_IDX_W-1:0] k;
        logic [1:0]            q;
        logic [QTR_W-1:0]      r;
        logic [QTR_W-1:0]      r_mirror;
        t_mag                  mag;
        k        = angle[ANGLE_W-1 -: SINE_IDX_W];
        q        = k[SINE_IDX_W-1 -: 2];
        r        = k[QTR_W-1:0];
        r_mirror = ~r + {{(QTR_W-1){1'b0}}, 1'b1};
        if (!q[0]) begin
            mag = QTR_TABLE[r];
        end else if (r == '0) begin
            // The top of the quarter wave lies one past the end of the table.
            mag = MAG_PEAK;
        end else begin
            mag = QTR_TABLE[r_mirror];
        end
        return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

### src/day_night_terminator_shader.sv
// Each accepted item passes through the register stages in order and is offered at the output from the last.
// Throughput: one item per cycle while the output is ready; five register stages, each advancing when empty
// or when the stage after it advances, so bubbles close up under a stall.
// Reset (synchronous, active low) empties the pipeline and clears the sun position
// and mono mode to zero; it takes effect at the next rising clock edge.
module day_night_terminator_shader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dnts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dnts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // column [7:0], row [14:8], day_colour [22:15], night_colour [30:23], world_bit [31]
    input  logic [dnts_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // pixel_value [7:0], is_dark [8], zero [15:9]
    output logic [dnts_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import dnts_pkg::*;

    logic [ANGLE_W-1:0]  r_sun_longitude;
    logic [ANGLE_W-1:0]  r_sun_declination;
    logic                r_mono_mode;

    logic [5:1]          r_vld;
    logic [5:1]          w_adv;

    logic [COLUMN_W-1:0] w_column;
    logic [ROW_W-1:0]    w_row;
    t_pixel              w_pixel;

    t_angle              r1_lat;
    t_angle              r1_hour;
    t_pixel              r1_pix;

    t_trig               r2_s1;
    t_trig               r2_c1;
    t_trig               r2_s2;
    t_trig               r2_c2;
    t_trig               r2_c3;
    t_pixel              r2_pix;

    logic signed [PROD_W-1:0] w_p1;
    logic signed [PROD_W-1:0] w_p2;
    logic signed [PROD_W-1:0] r3_p1;
    logic signed [PROD_W-1:0] r3_p2;
    t_trig                    r3_c3;
    t_pixel                   r3_pix;

    logic signed [SUM_W-1:0]  w_prod_b;
    logic signed [SUM_W-1:0]  r4_a;
    logic signed [SUM_W-1:0]  r4_b;
    t_pixel                   r4_pix;

    logic signed [SUM_W-1:0]  n_sum;
    logic                     n_dark;
    logic [COLOUR_W-1:0]      n_pixel;
    logic                     r5_dark;
    logic [COLOUR_W-1:0]      r5_pixel;

    assign w_column = i_s_axis_tdata[COLUMN_W-1:0];
    assign w_row    = i_s_axis_tdata[COLUMN_W +: ROW_W];
    assign w_pixel  = '{day_colour:   i_s_axis_tdata[COLUMN_W + ROW_W +: COLOUR_W],
                        night_colour: i_s_axis_tdata[COLUMN_W + ROW_W + COLOUR_W +: COLOUR_W],
                        world_bit:    i_s_axis_tdata[COLUMN_W + ROW_W + 2 * COLOUR_W]};

    // A stage may load when it is empty or when its contents move on.
    assign w_adv[5] = !r_vld[5] || i_m_axis_tready;
    assign w_adv[4] = !r_vld[4] || w_adv[5];
    assign w_adv[3] = !r_vld[3] || w_adv[4];
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];

    assign o_s_axis_tready = w_adv[1];
    assign o_m_axis_tvalid = r_vld[5];
    assign o_m_axis_tdata  = {{(OUT_DATA_W - COLOUR_W - 1){1'b0}}, r5_dark, r5_pixel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sun_longitude   <= '0;
            r_sun_declination <= '0;
            r_mono_mode       <= 1'b0;
            r_vld             <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SUN_LONGITUDE:   r_sun_longitude   <= i_cfg_data[ANGLE_W-1:0];
                    CFG_SUN_DECLINATION: r_sun_declination <= i_cfg_data[ANGLE_W-1:0];
                    CFG_MONO_MODE:       r_mono_mode       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_adv[1]) r_vld[1] <= i_s_axis_tvalid;
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
            if (w_adv[4]) r_vld[4] <= r_vld[3];
            if (w_adv[5]) r_vld[5] <= r_vld[4];
        end
    end

    assign w_p1     = PROD_W'(r2_s1) * PROD_W'(r2_s2);
    assign w_p2     = PROD_W'(r2_c1) * PROD_W'(r2_c2);
    assign w_prod_b = SUM_W'(r3_p2) * SUM_W'(r3_c3);

    assign n_sum  = r4_a + r4_b;
    // A sum of exactly zero counts as lit.
    assign n_dark = n_sum[SUM_W-1];

    always_comb begin
        if (r_mono_mode) begin
            n_pixel = {{(COLOUR_W-1){1'b0}}, n_dark ^ r4_pix.world_bit};
        end else if (n_dark) begin
            n_pixel = r4_pix.night_colour;
        end else begin
            n_pixel = r4_pix.day_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_lat  <= LAT_TABLE[w_row];
            // Cosine of the hour angle is taken as the sine a quarter turn on.
            r1_hour <= r_sun_longitude - LON_TABLE[w_column] + QUARTER_TURN;
            r1_pix  <= w_pixel;
        end
        if (w_adv[2]) begin
            r2_s1  <= sine_lookup(r_sun_declination);
            r2_c1  <= sine_lookup(r_sun_declination + QUARTER_TURN);
            r2_s2  <= sine_lookup(r1_lat);
            r2_c2  <= sine_lookup(r1_lat + QUARTER_TURN);
            r2_c3  <= sine_lookup(r1_hour);
            r2_pix <= r1_pix;
        end
        if (w_adv[3]) begin
            r3_p1  <= w_p1;
            r3_p2  <= w_p2;
            r3_c3  <= r2_c3;
            r3_pix <= r2_pix;
        end
        if (w_adv[4]) begin
            // Times 65535 as a shift and a subtract.
            r4_a   <= (SUM_W'(r3_p1) <<< 16) - SUM_W'(r3_p1);
            r4_b   <= w_prod_b;
            r4_pix <= r3_pix;
        end
        if (w_adv[5]) begin
            r5_dark  <= n_dark;
            r5_pixel <= n_pixel;
        end
    end

endmodule

### src/dnts_checker.sv
`include "assert_macros.svh"

module dnts_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_s_axis_tready,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [dnts_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // A result that is not taken stays offered.
    `ASSERT_CLK(a_out_valid_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)

    // A result that is not taken keeps its value.
    `ASSERT_CLK(a_out_data_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))

    // With nothing waiting at the output, every stage can move, so the input side is open.
    `ASSERT_CLK(a_ready_when_drained, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)

    // Reset leaves the pipeline empty.
    `ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n) |-> !o_m_axis_tvalid)

endmodule

bind day_night_terminator_shader dnts_checker u_dnts_checker (.*);
